@@ hw/rtl/hash_set_intersection_core_assert.svh @@
// Assertion macros for the hash set intersection core checker.
`ifndef HASH_SET_INTERSECTION_CORE_ASSERT_SVH
`define HASH_SET_INTERSECTION_CORE_ASSERT_SVH

// Clocked assertion, off while in reset.
`define HSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define HSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hsi_pkg.sv @@
// Shared types, constants and hash function for the hash set intersection core.
package hsi_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_PROBE  = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               is_common;
        logic               table_full;
    } out_word_t;

    typedef struct packed {
        logic        used;
        logic        emitted;
        logic [31:0] key;
    } slot_entry_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Table size is a power of two: the slot is the low bits of the product.
    function automatic logic [SLOT_W-1:0] home_slot(logic [31:0] key);
        logic [31:0] h;
        h = key * HASH_MULT;
        return h[SLOT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/hsi_ram.sv @@
// Single-port-write, single-port-read slot memory with registered read data.
module hsi_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 34
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hsi_ctrl.sv @@
// Probe sequencer: hashes, walks slots through the shared compare, updates the table.
module hsi_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hsi_pkg::in_word_t        in_word,
    output hsi_pkg::result_t         res,
    input  logic                     res_ack,
    output logic                     ram_we,
    output logic [hsi_pkg::SLOT_W-1:0]  ram_waddr,
    output hsi_pkg::slot_entry_t     ram_wdata,
    output logic [hsi_pkg::SLOT_W-1:0]  ram_raddr,
    input  hsi_pkg::slot_entry_t     ram_rdata
);
    import hsi_pkg::*;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               clr_item_reg, clr_item_next;
    logic [1:0]         func_reg, func_next;
    logic [31:0]        key_reg, key_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   used_count_reg, used_count_next;
    logic               common_reg, common_next;
    logic               full_reg, full_next;
    logic               miss;
    logic               key_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_item_reg   <= 1'b0;
            used_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_item_reg   <= clr_item_next;
            used_count_reg <= used_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        step_reg   <= step_next;
        common_reg <= common_next;
        full_reg   <= full_next;
    end

    assign key_match = (ram_rdata.key == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_item_next   = clr_item_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        step_next       = step_reg;
        used_count_next = used_count_reg;
        common_next     = common_reg;
        full_next       = full_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = '0;
        ram_raddr       = slot_reg;
        miss            = 1'b0;
        res.valid       = 1'b0;
        res.word.value_out  = key_reg;
        res.word.is_common  = common_reg;
        res.word.table_full = full_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = clr_addr_reg;
                used_count_next = '0;
                clr_addr_next   = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next   = in_word.func;
                    key_next    = in_word.value;
                    slot_next   = home_slot(in_word.value);
                    step_next   = '0;
                    common_next = 1'b0;
                    full_next   = 1'b0;
                    unique case (in_word.func)
                        FUNC_INSERT, FUNC_PROBE: state_next = ST_LOOK;
                        FUNC_CLEAR:
                        begin
                            clr_item_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOOK:
            begin
                // every occupied slot already compared: the slot reached is free unless the table is full
                if (step_reg == used_count_reg)
                begin
                    miss       = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!ram_rdata.used)
                begin
                    miss       = 1'b1;
                    state_next = ST_DONE;
                end
                else if (key_match)
                begin
                    if (func_reg == FUNC_PROBE && !ram_rdata.emitted)
                    begin
                        ram_we            = 1'b1;
                        ram_wdata.used    = 1'b1;
                        ram_wdata.emitted = 1'b1;
                        ram_wdata.key     = key_reg;
                        common_next       = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (miss && func_reg == FUNC_INSERT)
        begin
            if (used_count_reg == CNT_W'(TABLE_SLOTS))
            begin
                full_next = 1'b1;
            end
            else
            begin
                ram_we            = 1'b1;
                ram_wdata.used    = 1'b1;
                ram_wdata.emitted = 1'b0;
                ram_wdata.key     = key_reg;
                used_count_next   = used_count_reg + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/hash_set_intersection_core.sv @@
// Hash set intersection core: top level with slot memory, sequencer and output register.
//
// Input words (valid/ready) carry func and value: func 0 inserts value into the
// table, func 1 probes it and reports it once as common, func 2 clears all slots,
// func 3 is echoed unchanged. Every input word gives exactly one output word,
// in order, echoing the value with is_common and table_full flags.
// One word is in flight at a time; in_ready is low while it is worked on.
// Insert/probe: the value is hashed to its home slot, then each slot visited by
// linear probing is read from the registered memory and then compared, and the
// result is handed off to the output register.
// A walk ends early once all occupied slots have been compared.
// Clear: one memory write per slot, over all TABLE_SLOTS slots.
// After reset the same clearing pass runs with in_ready low.
// The output register frees the sequencer: a new input word is taken while the
// previous result waits; if out_ready stays low, the next result waits in the
// sequencer and in_ready stays low until the output register frees up.
module hash_set_intersection_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsi_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output hsi_pkg::out_word_t out_word
);
    import hsi_pkg::*;

    result_t           res;
    logic              res_ack;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    slot_entry_t       ram_wdata;
    slot_entry_t       ram_rdata;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    hsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .res       (res),
        .res_ack   (res_ack),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    hsi_ram #(
        .ADDR_W (SLOT_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ack = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res.word;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ hw/rtl/hsi_checker.sv @@
// Port-level checker for the hash set intersection core, bound to the top level.
`include "hash_set_intersection_core_assert.svh"

module hsi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input hsi_pkg::in_word_t  in_word,
    input logic               out_valid,
    input logic               out_ready,
    input hsi_pkg::out_word_t out_word
);
    import hsi_pkg::*;

    `HSI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "output word changed while stalled")
    `HSI_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted a word while busy")
    `HSI_ASSERT(a_clear_sweeps, in_valid && in_ready && in_word.func == FUNC_CLEAR |=> !in_ready ##1 !in_ready, "clear finished too early")
    `HSI_ASSERT_ALWAYS(a_flags_exclusive, out_valid |-> !(out_word.is_common && out_word.table_full), "both result flags set")

endmodule

bind hash_set_intersection_core hsi_checker u_hsi_checker (.*);
